/* sv/farthest_point_pair_core_macros.svh */
// Assertion macros for the farthest point pair core.
`ifndef FARTHEST_POINT_PAIR_CORE_MACROS_SVH
`define FARTHEST_POINT_PAIR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Whenever ante_ holds, cons_ must hold in the same cycle.
`define FPP_ASSERT_IMPLY(label_, clk_, rst_n_, ante_, cons_) \
    label_: assert property (@(posedge clk_) disable iff (!rst_n_) \
        (ante_) |-> (cons_)) else $error("fpp assertion failed");

// Whenever ante_ holds, cons_ must hold in the next cycle.
`define FPP_ASSERT_NEXT(label_, clk_, rst_n_, ante_, cons_) \
    label_: assert property (@(posedge clk_) disable iff (!rst_n_) \
        (ante_) |=> (cons_)) else $error("fpp assertion failed");

`else

`define FPP_ASSERT_IMPLY(label_, clk_, rst_n_, ante_, cons_)
`define FPP_ASSERT_NEXT(label_, clk_, rst_n_, ante_, cons_)

`endif

`endif

/* sv/fpp_pkg.sv */
// Shared constants and controller/datapath interface types.
`default_nettype none

package fpp_pkg;

    localparam int FPP_MAX_POINTS = 1024;
    localparam int FPP_COORD_BITS = 20;

    // Fixed widths of the result fields.
    localparam int OUT_IDX_BITS  = 10;
    localparam int OUT_DSQ_BITS  = 42;
    localparam int OUT_DIST_BITS = 21;

    typedef struct packed {
        logic load_point;
        logic scan_init;
        logic issue_row;
        logic issue_col;
        logic next_row;
        logic advance_col;
        logic fetch_first;
        logic fetch_second;
        logic cap_first;
        logic cap_second;
        logic sqrt_start;
        logic post_result;
    } fpp_cmd_t;

    typedef struct packed {
        logic few_points;
        logic col_last;
        logic row_last;
        logic pipe_busy;
        logic sqrt_busy;
        logic out_busy;
    } fpp_stat_t;

endpackage

`default_nettype wire

/* sv/farthest_point_pair_core.sv */
// Top level of the brute-force 3D farthest point pair core.
//
//   channel   direction  handshake              beat contents
//   in        sink       in_valid / in_stall    coord_x, coord_y, coord_z, last_point
//   out       source     out_valid / out_stall  found, indices, endpoints, dist_squared,
//                                               distance, overflow
//
// Points load at one beat per cycle into a single-port-read point store.
// After the last point in_stall stays high until the result is posted: for n >= 2
// stored points through one store read per pair and one per row, a pipeline drain,
// the endpoint fetch and the bit-serial square root (COORD_BITS+1 steps).
// The post also waits while the previous result beat is still held under out_stall.
// rst_n clears control, counters and the best pair; the point store is not cleared.
`default_nettype none

module farthest_point_pair_core
    import fpp_pkg::*;
#(
    parameter int MAX_POINTS = FPP_MAX_POINTS,
    parameter int COORD_BITS = FPP_COORD_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic signed [COORD_BITS-1:0]  coord_x,
    input  wire logic signed [COORD_BITS-1:0]  coord_y,
    input  wire logic signed [COORD_BITS-1:0]  coord_z,
    input  wire logic                          last_point,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic                          found,
    output      logic [OUT_IDX_BITS-1:0]       first_index,
    output      logic [OUT_IDX_BITS-1:0]       second_index,
    output      logic signed [COORD_BITS-1:0]  first_x,
    output      logic signed [COORD_BITS-1:0]  first_y,
    output      logic signed [COORD_BITS-1:0]  first_z,
    output      logic signed [COORD_BITS-1:0]  second_x,
    output      logic signed [COORD_BITS-1:0]  second_y,
    output      logic signed [COORD_BITS-1:0]  second_z,
    output      logic [OUT_DSQ_BITS-1:0]       dist_squared,
    output      logic [OUT_DIST_BITS-1:0]      distance,
    output      logic                          overflow
);

`include "farthest_point_pair_core_macros.svh"

    fpp_cmd_t  cmd;
    fpp_stat_t stat;

    fpp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_point (last_point),
        .stat       (stat),
        .cmd        (cmd)
    );

    fpp_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .first_index  (first_index),
        .second_index (second_index),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .dist_squared (dist_squared),
        .distance     (distance),
        .overflow     (overflow)
    );

    // A result never overwrites a beat still waiting at the output.
    `FPP_ASSERT_IMPLY(a_post_free, clk, rst_n, cmd.post_result, !stat.out_busy)
    // The root starts only after every pair has been compared.
    `FPP_ASSERT_IMPLY(a_sqrt_after_scan, clk, rst_n, cmd.sqrt_start, !stat.pipe_busy)
    // Loading resumes only with the scan pipeline and root unit idle.
    `FPP_ASSERT_IMPLY(a_load_idle, clk, rst_n, !in_stall, !stat.pipe_busy && !stat.sqrt_busy)
    // A posted result shows up as a valid beat on the next cycle.
    `FPP_ASSERT_NEXT(a_post_valid, clk, rst_n, cmd.post_result, out_valid)

endmodule

`default_nettype wire

/* sv/fpp_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module fpp_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/fpp_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
`default_nettype none

module fpp_isqrt #(
    parameter int ROOT_W = 21
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    output      logic                  busy,
    output      logic [ROOT_W-1:0]     root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    trial;
    logic                take;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[2*ROOT_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);
    assign busy      = (cnt_reg != '0);
    assign root      = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(ROOT_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy)
        begin
            rad_reg <= {rad_reg[2*ROOT_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

/* sv/fpp_datapath.sv */
// Point store, pair distance pipeline, best-pair tracking and result registers.
`default_nettype none

module fpp_datapath
    import fpp_pkg::*;
#(
    parameter int MAX_POINTS = FPP_MAX_POINTS,
    parameter int COORD_BITS = FPP_COORD_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fpp_cmd_t                      cmd,
    output      fpp_stat_t                     stat,
    input  wire logic signed [COORD_BITS-1:0]  coord_x,
    input  wire logic signed [COORD_BITS-1:0]  coord_y,
    input  wire logic signed [COORD_BITS-1:0]  coord_z,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic                          found,
    output      logic [OUT_IDX_BITS-1:0]       first_index,
    output      logic [OUT_IDX_BITS-1:0]       second_index,
    output      logic signed [COORD_BITS-1:0]  first_x,
    output      logic signed [COORD_BITS-1:0]  first_y,
    output      logic signed [COORD_BITS-1:0]  first_z,
    output      logic signed [COORD_BITS-1:0]  second_x,
    output      logic signed [COORD_BITS-1:0]  second_y,
    output      logic signed [COORD_BITS-1:0]  second_z,
    output      logic [OUT_DSQ_BITS-1:0]       dist_squared,
    output      logic [OUT_DIST_BITS-1:0]      distance,
    output      logic                          overflow
);

    localparam int C      = COORD_BITS;
    localparam int PT_W   = 3 * C;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SQ_W   = 2 * C;
    localparam int DSQ_W  = 2 * C + 2;
    localparam int ROOT_W = C + 1;

    // Load bookkeeping
    logic [CNT_W-1:0]  count_reg;
    logic              dropped_reg;
    logic              store_full;

    // Scan counters
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] i_plus1;

    // Store access
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PT_W-1:0]   ram_rdata;

    // Pipeline
    logic              p1_valid_reg;
    logic              p1_row_reg;
    logic [ADDR_W-1:0] p1_i_reg;
    logic [ADDR_W-1:0] p1_j_reg;

    logic [PT_W-1:0]   a_pt_reg;

    logic              p2_valid_reg;
    logic [ADDR_W-1:0] p2_i_reg;
    logic [ADDR_W-1:0] p2_j_reg;
    logic signed [C:0] p2_dx_reg;
    logic signed [C:0] p2_dy_reg;
    logic signed [C:0] p2_dz_reg;
    logic signed [C:0] p2_dx_next;
    logic signed [C:0] p2_dy_next;
    logic signed [C:0] p2_dz_next;

    logic signed [2*C+1:0] prod_x;
    logic signed [2*C+1:0] prod_y;
    logic signed [2*C+1:0] prod_z;

    logic              p3_valid_reg;
    logic [ADDR_W-1:0] p3_i_reg;
    logic [ADDR_W-1:0] p3_j_reg;
    logic [SQ_W-1:0]   p3_sqx_reg;
    logic [SQ_W-1:0]   p3_sqy_reg;
    logic [SQ_W-1:0]   p3_sqz_reg;

    logic              p4_valid_reg;
    logic [ADDR_W-1:0] p4_i_reg;
    logic [ADDR_W-1:0] p4_j_reg;
    logic [DSQ_W-1:0]  p4_sum_reg;
    logic [DSQ_W-1:0]  p4_sum_next;

    // Best pair
    logic [ADDR_W-1:0] best_first_reg;
    logic [ADDR_W-1:0] best_second_reg;
    logic [DSQ_W-1:0]  best_dsq_reg;
    logic              best_found;

    logic [PT_W-1:0]   first_pt_reg;
    logic [PT_W-1:0]   second_pt_reg;

    logic              sqrt_busy;
    logic [ROOT_W-1:0] sqrt_root;

    logic              out_valid_reg;

    assign store_full = (count_reg == CNT_W'(MAX_POINTS));
    assign ram_we     = cmd.load_point && !store_full;
    assign i_plus1    = i_reg + 1'b1;

    always_comb
    begin
        ram_re    = cmd.issue_row || cmd.issue_col || cmd.fetch_first || cmd.fetch_second;
        ram_raddr = i_reg;
        if (cmd.issue_col)
        begin
            ram_raddr = j_reg;
        end
        else if (cmd.fetch_first)
        begin
            ram_raddr = best_first_reg;
        end
        else if (cmd.fetch_second)
        begin
            ram_raddr = best_second_reg;
        end
    end

    fpp_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({coord_x, coord_y, coord_z}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Load count and drop flag; clear both once the result is posted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.post_result)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.load_point)
        begin
            if (store_full)
            begin
                dropped_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            i_reg <= '0;
            j_reg <= ADDR_W'(1);
        end
        else if (cmd.next_row)
        begin
            i_reg <= i_plus1;
            j_reg <= i_plus1 + 1'b1;
        end
        else if (cmd.advance_col)
        begin
            j_reg <= j_reg + 1'b1;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.issue_row || cmd.issue_col;
            p2_valid_reg <= p1_valid_reg && !p1_row_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    assign p2_dx_next = {a_pt_reg[3*C-1], a_pt_reg[3*C-1:2*C]}
                      - {ram_rdata[3*C-1], ram_rdata[3*C-1:2*C]};
    assign p2_dy_next = {a_pt_reg[2*C-1], a_pt_reg[2*C-1:C]}
                      - {ram_rdata[2*C-1], ram_rdata[2*C-1:C]};
    assign p2_dz_next = {a_pt_reg[C-1], a_pt_reg[C-1:0]}
                      - {ram_rdata[C-1], ram_rdata[C-1:0]};

    assign prod_x = p2_dx_reg * p2_dx_reg;
    assign prod_y = p2_dy_reg * p2_dy_reg;
    assign prod_z = p2_dz_reg * p2_dz_reg;

    assign p4_sum_next = DSQ_W'(p3_sqx_reg) + DSQ_W'(p3_sqy_reg) + DSQ_W'(p3_sqz_reg);

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        p1_row_reg <= cmd.issue_row;
        p1_i_reg   <= i_reg;
        p1_j_reg   <= j_reg;

        // Row beat: latch the fixed endpoint for the columns that follow.
        if (p1_valid_reg && p1_row_reg)
        begin
            a_pt_reg <= ram_rdata;
        end

        p2_i_reg  <= p1_i_reg;
        p2_j_reg  <= p1_j_reg;
        p2_dx_reg <= p2_dx_next;
        p2_dy_reg <= p2_dy_next;
        p2_dz_reg <= p2_dz_next;

        p3_i_reg   <= p2_i_reg;
        p3_j_reg   <= p2_j_reg;
        p3_sqx_reg <= prod_x[SQ_W-1:0];
        p3_sqy_reg <= prod_y[SQ_W-1:0];
        p3_sqz_reg <= prod_z[SQ_W-1:0];

        p4_i_reg   <= p3_i_reg;
        p4_j_reg   <= p3_j_reg;
        p4_sum_reg <= p4_sum_next;

        if (cmd.cap_first)
        begin
            first_pt_reg <= ram_rdata;
        end
        if (cmd.cap_second)
        begin
            second_pt_reg <= ram_rdata;
        end
    end

    // Strictly larger wins, so the earliest pair keeps a tie.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_first_reg  <= '0;
            best_second_reg <= '0;
            best_dsq_reg    <= '0;
        end
        else if (cmd.scan_init)
        begin
            best_first_reg  <= '0;
            best_second_reg <= '0;
            best_dsq_reg    <= '0;
        end
        else if (p4_valid_reg && (p4_sum_reg > best_dsq_reg))
        begin
            best_first_reg  <= p4_i_reg;
            best_second_reg <= p4_j_reg;
            best_dsq_reg    <= p4_sum_reg;
        end
    end

    assign best_found = (best_dsq_reg != '0);

    fpp_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (best_dsq_reg),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    // Result register: hold the beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post_result)
        begin
            found    <= best_found;
            overflow <= dropped_reg;
            if (best_found)
            begin
                first_index  <= OUT_IDX_BITS'(best_first_reg);
                second_index <= OUT_IDX_BITS'(best_second_reg);
                first_x      <= first_pt_reg[3*C-1:2*C];
                first_y      <= first_pt_reg[2*C-1:C];
                first_z      <= first_pt_reg[C-1:0];
                second_x     <= second_pt_reg[3*C-1:2*C];
                second_y     <= second_pt_reg[2*C-1:C];
                second_z     <= second_pt_reg[C-1:0];
                dist_squared <= OUT_DSQ_BITS'(best_dsq_reg);
                distance     <= OUT_DIST_BITS'(sqrt_root);
            end
            else
            begin
                first_index  <= '0;
                second_index <= '0;
                first_x      <= '0;
                first_y      <= '0;
                first_z      <= '0;
                second_x     <= '0;
                second_y     <= '0;
                second_z     <= '0;
                dist_squared <= '0;
                distance     <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        stat.few_points = (count_reg < CNT_W'(2));
        stat.col_last   = (CNT_W'(j_reg) == (count_reg - CNT_W'(1)));
        stat.row_last   = (CNT_W'(i_reg) == (count_reg - CNT_W'(2)));
        stat.pipe_busy  = p1_valid_reg || p2_valid_reg || p3_valid_reg || p4_valid_reg;
        stat.sqrt_busy  = sqrt_busy;
        stat.out_busy   = out_valid_reg;
    end

endmodule

`default_nettype wire

/* sv/fpp_ctrl.sv */
// Controller: load, pair scan sequencing, endpoint fetch and result post.
`default_nettype none

module fpp_ctrl
    import fpp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output      logic      in_stall,
    input  wire logic      last_point,
    input  wire fpp_stat_t stat,
    output      fpp_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_START   = 4'd1;
    localparam logic [3:0] ST_ROW     = 4'd2;
    localparam logic [3:0] ST_COL     = 4'd3;
    localparam logic [3:0] ST_DRAIN   = 4'd4;
    localparam logic [3:0] ST_FETCH_A = 4'd5;
    localparam logic [3:0] ST_FETCH_B = 4'd6;
    localparam logic [3:0] ST_CAP_B   = 4'd7;
    localparam logic [3:0] ST_FINISH  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_point = 1'b1;
                    if (last_point)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_START;
                    end
                end
            end
            ST_START:
            begin
                state_next = stat.few_points ? ST_FINISH : ST_ROW;
            end
            ST_ROW:
            begin
                cmd.issue_row = 1'b1;
                state_next    = ST_COL;
            end
            ST_COL:
            begin
                cmd.issue_col = 1'b1;
                if (stat.col_last)
                begin
                    if (stat.row_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.next_row = 1'b1;
                        state_next   = ST_ROW;
                    end
                end
                else
                begin
                    cmd.advance_col = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_FETCH_A;
                end
            end
            ST_FETCH_A:
            begin
                cmd.fetch_first = 1'b1;
                cmd.sqrt_start  = 1'b1;
                state_next      = ST_FETCH_B;
            end
            ST_FETCH_B:
            begin
                cmd.fetch_second = 1'b1;
                cmd.cap_first    = 1'b1;
                state_next       = ST_CAP_B;
            end
            ST_CAP_B:
            begin
                cmd.cap_second = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait for the root and a free result register.
                if (!stat.out_busy && !stat.sqrt_busy)
                begin
                    cmd.post_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* tb/sv/fpp_pair_checker.sv */
// Checker for the farthest point pair core: predicts each result beat and compares it.
`timescale 1ns / 100ps

module fpp_pair_checker
    import fpp_pkg::*;
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic signed [FPP_COORD_BITS-1:0]  coord_x,
    input  wire logic signed [FPP_COORD_BITS-1:0]  coord_y,
    input  wire logic signed [FPP_COORD_BITS-1:0]  coord_z,
    input  wire logic                              last_point,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic                              found,
    input  wire logic [OUT_IDX_BITS-1:0]           first_index,
    input  wire logic [OUT_IDX_BITS-1:0]           second_index,
    input  wire logic signed [FPP_COORD_BITS-1:0]  first_x,
    input  wire logic signed [FPP_COORD_BITS-1:0]  first_y,
    input  wire logic signed [FPP_COORD_BITS-1:0]  first_z,
    input  wire logic signed [FPP_COORD_BITS-1:0]  second_x,
    input  wire logic signed [FPP_COORD_BITS-1:0]  second_y,
    input  wire logic signed [FPP_COORD_BITS-1:0]  second_z,
    input  wire logic [OUT_DSQ_BITS-1:0]           dist_squared,
    input  wire logic [OUT_DIST_BITS-1:0]          distance,
    input  wire logic                              overflow,
    output int                                     errors,
    output int                                     waiting
);

    typedef struct {
        logic                              found;
        logic [OUT_IDX_BITS-1:0]           idx_a;
        logic [OUT_IDX_BITS-1:0]           idx_b;
        logic signed [FPP_COORD_BITS-1:0]  ax;
        logic signed [FPP_COORD_BITS-1:0]  ay;
        logic signed [FPP_COORD_BITS-1:0]  az;
        logic signed [FPP_COORD_BITS-1:0]  bx;
        logic signed [FPP_COORD_BITS-1:0]  by;
        logic signed [FPP_COORD_BITS-1:0]  bz;
        logic [OUT_DSQ_BITS-1:0]           dsq;
        logic [OUT_DIST_BITS-1:0]          root;
        logic                              lost;
    } pair_result_t;

    logic signed [FPP_COORD_BITS-1:0] pt_x [FPP_MAX_POINTS];
    logic signed [FPP_COORD_BITS-1:0] pt_y [FPP_MAX_POINTS];
    logic signed [FPP_COORD_BITS-1:0] pt_z [FPP_MAX_POINTS];
    int           stored;
    bit           lost;
    pair_result_t awaited_pairs [$];
    pair_result_t want;

    initial
    begin
        errors  = 0;
        waiting = 0;
        stored  = 0;
        lost    = 1'b0;
    end

    function automatic logic [OUT_DIST_BITS-1:0] floor_root(logic [OUT_DSQ_BITS-1:0] v);
        logic [OUT_DIST_BITS-1:0] r;
        logic [OUT_DIST_BITS-1:0] trial;
        logic [63:0]              sq;
        int                       b;
        r = '0;
        // settle one root bit at a time, highest first
        for (b = OUT_DIST_BITS - 1; b >= 0; b--)
        begin
            trial = r | (OUT_DIST_BITS'(1) << b);
            sq    = 64'(trial) * 64'(trial);
            if (sq <= 64'(v))
                r = trial;
        end
        return r;
    endfunction

    function automatic longint pair_dist_sq(int a, int b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(pt_x[a]) - longint'(pt_x[b]);
        dy = longint'(pt_y[a]) - longint'(pt_y[b]);
        dz = longint'(pt_z[a]) - longint'(pt_z[b]);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic pair_result_t scan_set();
        pair_result_t res;
        longint       best;
        longint       d;
        int           i;
        int           j;
        int           bi;
        int           bj;
        best = 0;
        bi   = 0;
        bj   = 0;
        // strict compare: the first pair reaching the maximum keeps it
        for (i = 0; i + 1 < stored; i++)
            for (j = i + 1; j < stored; j++)
            begin
                d = pair_dist_sq(i, j);
                if (d > best)
                begin
                    best = d;
                    bi   = i;
                    bj   = j;
                end
            end
        res.found = (best != 0);
        res.idx_a = '0;
        res.idx_b = '0;
        res.ax    = '0;
        res.ay    = '0;
        res.az    = '0;
        res.bx    = '0;
        res.by    = '0;
        res.bz    = '0;
        res.dsq   = '0;
        res.root  = '0;
        res.lost  = lost;
        if (res.found)
        begin
            res.idx_a = OUT_IDX_BITS'(bi);
            res.idx_b = OUT_IDX_BITS'(bj);
            res.ax    = pt_x[bi];
            res.ay    = pt_y[bi];
            res.az    = pt_z[bi];
            res.bx    = pt_x[bj];
            res.by    = pt_y[bj];
            res.bz    = pt_z[bj];
            res.dsq   = best[OUT_DSQ_BITS-1:0];
            res.root  = floor_root(res.dsq);
        end
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
        $display("%0t mismatch %s: got %0h, wanted %0h", $realtime, what, got, wanted);
        errors++;
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] wanted);
        if (got !== wanted)
            note_mismatch(what, got, wanted);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored = 0;
            lost   = 1'b0;
            awaited_pairs.delete();
            waiting = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_pairs.size() == 0)
                    note_mismatch("result beat with nothing awaited", 64'(found), 64'd0);
                else
                begin
                    want = awaited_pairs.pop_front();
                    check_field("found", found, want.found);
                    check_field("first_index", first_index, want.idx_a);
                    check_field("second_index", second_index, want.idx_b);
                    check_field("first_x", first_x, want.ax);
                    check_field("first_y", first_y, want.ay);
                    check_field("first_z", first_z, want.az);
                    check_field("second_x", second_x, want.bx);
                    check_field("second_y", second_y, want.by);
                    check_field("second_z", second_z, want.bz);
                    check_field("dist_squared", dist_squared, want.dsq);
                    check_field("distance", distance, want.root);
                    check_field("overflow", overflow, want.lost);
                end
            end
            if (in_valid && !in_stall)
            begin
                // drop points past capacity, but remember it
                if (stored < FPP_MAX_POINTS)
                begin
                    pt_x[stored] = coord_x;
                    pt_y[stored] = coord_y;
                    pt_z[stored] = coord_z;
                    stored++;
                end
                else
                    lost = 1'b1;
                if (last_point)
                begin
                    awaited_pairs = {awaited_pairs, scan_set()};
                    stored = 0;
                    lost   = 1'b0;
                end
            end
            waiting = awaited_pairs.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the farthest point pair core: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
    import fpp_pkg::*;

    typedef logic signed [FPP_COORD_BITS-1:0] coord_t;

    localparam int     IDLE_PCT       = 23;
    localparam int     TOTAL_POINTS   = 1650;
    localparam int     BIG_SET_POINTS = FPP_MAX_POINTS + 3;
    localparam int     WATCHDOG_LIMIT = 2_000_000;
    localparam int     DRAIN_CYCLES   = 64;
    localparam coord_t COORD_MIN      = {1'b1, {(FPP_COORD_BITS-1){1'b0}}};
    localparam coord_t COORD_MAX      = {1'b0, {(FPP_COORD_BITS-1){1'b1}}};

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    coord_t                        coord_x;
    coord_t                        coord_y;
    coord_t                        coord_z;
    logic                          last_point;
    logic                          out_valid;
    logic                          out_stall;
    logic                          found;
    logic [OUT_IDX_BITS-1:0]       first_index;
    logic [OUT_IDX_BITS-1:0]       second_index;
    coord_t                        first_x;
    coord_t                        first_y;
    coord_t                        first_z;
    coord_t                        second_x;
    coord_t                        second_y;
    coord_t                        second_z;
    logic [OUT_DSQ_BITS-1:0]       dist_squared;
    logic [OUT_DIST_BITS-1:0]      distance;
    logic                          overflow;
    logic                          quiet;
    int                            errors;
    int                            waiting;
    int                            points_sent;
    int                            idle_run;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    farthest_point_pair_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .first_index  (first_index),
        .second_index (second_index),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .dist_squared (dist_squared),
        .distance     (distance),
        .overflow     (overflow)
    );

    fpp_pair_checker i_pair_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .first_index  (first_index),
        .second_index (second_index),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .dist_squared (dist_squared),
        .distance     (distance),
        .overflow     (overflow),
        .errors       (errors),
        .waiting      (waiting)
    );

    // stall the result side at random, except in the quiet stretch
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    function automatic coord_t pick_coord(int style);
        case (style)
            0:       return coord_t'($urandom);
            1:       return coord_t'(int'($urandom_range(16)) - 8);
            default:
                case ($urandom_range(3))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return coord_t'(0);
                    default: return coord_t'(-1);
                endcase
        endcase
    endfunction

    task automatic send_point(coord_t x, coord_t y, coord_t z, bit last);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        coord_x    <= x;
        coord_y    <= y;
        coord_z    <= z;
        last_point <= last;
        @(posedge clk);
        // hold the beat until it is taken
        while (in_stall)
            @(posedge clk);
        points_sent++;
    endtask

    task automatic send_set(int n, int style);
        int k;
        for (k = 0; k < n; k++)
            send_point(pick_coord(style), pick_coord(style), pick_coord(style), k == n - 1);
    endtask

    initial
    begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int  n;
        int  style;
        bit  big_done;
        points_sent = 0;
        big_done    = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        coord_x    <= '0;
        coord_y    <= '0;
        coord_z    <= '0;
        last_point <= 1'b0;
        out_stall  <= 1'b0;
        quiet      <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone point: nothing to pair
        send_point(coord_t'(7), coord_t'(-3), coord_t'(100), 1'b1);
        // two identical points
        send_point(coord_t'(-5), coord_t'(9), coord_t'(1), 1'b0);
        send_point(coord_t'(-5), coord_t'(9), coord_t'(1), 1'b1);
        // opposite corners of the coordinate range plus the origin
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
        // square: both diagonals tie, the earlier pair must win
        send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
        send_point(coord_t'(1), coord_t'(0), coord_t'(0), 1'b0);
        send_point(coord_t'(1), coord_t'(1), coord_t'(0), 1'b0);
        send_point(coord_t'(0), coord_t'(1), coord_t'(0), 1'b1);
        // full span along z only
        send_point(coord_t'(0), coord_t'(0), COORD_MIN, 1'b0);
        send_point(coord_t'(0), coord_t'(0), COORD_MAX, 1'b1);
        // several equal nonzero points
        send_point(COORD_MAX, coord_t'(-1), COORD_MIN, 1'b0);
        send_point(COORD_MAX, coord_t'(-1), COORD_MIN, 1'b0);
        send_point(COORD_MAX, coord_t'(-1), COORD_MIN, 1'b1);

        while (points_sent < TOTAL_POINTS)
        begin
            if (!big_done && points_sent >= 400)
            begin
                // overfill the store; the trailing points, the last one too, get dropped
                send_set(BIG_SET_POINTS, 0);
                big_done = 1'b1;
            end
            else
            begin
                quiet <= (points_sent >= 200 && points_sent < 330);
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                style = $urandom_range(9);
                if (style < 5)
                    send_set(n, 0);
                else if (style < 8)
                    send_set(n, 1);
                else
                    send_set(n, 2);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
